// ===== rtl/bzt_pkg.sv =====
// Shared types, datapath operation codes and helpers for the Bezier stroke tessellator.
package bzt_pkg;

  typedef logic signed [15:0] coord_t;

  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_SQ     = 5'd2;
  localparam logic [4:0] OP_WT     = 5'd3;
  localparam logic [4:0] OP_MAC    = 5'd4;
  localparam logic [4:0] OP_DPREP  = 5'd5;
  localparam logic [4:0] OP_DIV    = 5'd6;
  localparam logic [4:0] OP_DIVEND = 5'd7;
  localparam logic [4:0] OP_DIFF   = 5'd8;
  localparam logic [4:0] OP_SQR    = 5'd9;
  localparam logic [4:0] OP_SUM    = 5'd10;
  localparam logic [4:0] OP_SA     = 5'd11;
  localparam logic [4:0] OP_SB     = 5'd12;
  localparam logic [4:0] OP_SC     = 5'd13;
  localparam logic [4:0] OP_PERP   = 5'd14;
  localparam logic [4:0] OP_TRI0   = 5'd15;
  localparam logic [4:0] OP_TRI1   = 5'd16;

  typedef struct packed {
    logic [4:0] op;
    logic [5:0] pt_idx;
    logic [1:0] sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [5:0] seg_n;
  } status_t;

  function automatic coord_t sat16(input logic signed [16:0] v);
    coord_t r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/bezier_thick_line_tessellator.sv =====
// Top level of the cubic Bezier stroke tessellator with its configuration registers.
//
// A curve transfer is taken at a clock edge with start high and busy low; the four
// control points are sampled then. The block evaluates segment_count+1 curve points
// and emits two triangles per segment on the vert ports, each present for exactly
// one cycle with result_strobe high; last_triangle marks the final one. There is no
// back-pressure: the receiver must take every result when it is strobed.
// Each curve point goes through the four-step Bernstein accumulation and the 17-step
// shared rounding divider. Each segment then adds the squared-length terms, an 8-step
// binary search of the offset and the two triangle states. Busy stays high until the
// sequencer has issued the last triangle, and no new item is taken while busy.
// The second triangle of each pair is strobed in the cycle after the first. Register
// writes on cfg_write take effect at once and are only legal while idle. The datapath
// samples both registers when a transfer is accepted. Synchronous reset returns the
// sequencer to idle and sets both registers to 16.
module bezier_thick_line_tessellator
  import bzt_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     ctrl_a_x,
  input  coord_t     ctrl_a_y,
  input  coord_t     ctrl_b_x,
  input  coord_t     ctrl_b_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  output logic       result_strobe,
  output coord_t     vert0_x,
  output coord_t     vert0_y,
  output coord_t     vert1_x,
  output coord_t     vert1_y,
  output coord_t     vert2_x,
  output coord_t     vert2_y,
  output logic       last_triangle
);

  localparam logic REG_SEGMENT_COUNT    = 1'b0;
  localparam logic REG_STROKE_THICKNESS = 1'b1;

  logic [5:0] seg_cfg;
  logic [7:0] thick_cfg;
  cmd_t       cmd;
  status_t    status;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cfg   <= 6'd16;
      thick_cfg <= 8'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEGMENT_COUNT:    seg_cfg   <= cfg_data[5:0];
        REG_STROKE_THICKNESS: thick_cfg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bzt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  bzt_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .seg_cfg       (seg_cfg),
    .thick_cfg     (thick_cfg),
    .start_x       (start_x),
    .start_y       (start_y),
    .ctrl_a_x      (ctrl_a_x),
    .ctrl_a_y      (ctrl_a_y),
    .ctrl_b_x      (ctrl_b_x),
    .ctrl_b_y      (ctrl_b_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .result_strobe (result_strobe),
    .vert0_x       (vert0_x),
    .vert0_y       (vert0_y),
    .vert1_x       (vert1_x),
    .vert1_y       (vert1_y),
    .vert2_x       (vert2_x),
    .vert2_y       (vert2_y),
    .last_triangle (last_triangle)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_triangle |=> !result_strobe)
    else $error("result strobed after the last triangle");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_triangle |-> busy)
    else $error("non-final triangle while idle");

endmodule

// ===== rtl/bzt_ctrl.sv =====
// Sequencer that steps the datapath through curve points, divisions and stroke offsets.
module bzt_ctrl
  import bzt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_WT     = 4'd2;
  localparam logic [3:0] S_MAC    = 4'd3;
  localparam logic [3:0] S_DPREP  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DIVEND = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_SQR    = 4'd8;
  localparam logic [3:0] S_SUM    = 4'd9;
  localparam logic [3:0] S_SA     = 4'd10;
  localparam logic [3:0] S_SB     = 4'd11;
  localparam logic [3:0] S_SC     = 4'd12;
  localparam logic [3:0] S_PERP   = 4'd13;
  localparam logic [3:0] S_TRI0   = 4'd14;
  localparam logic [3:0] S_TRI1   = 4'd15;

  logic [3:0] state;
  logic [5:0] pt_idx;
  logic [1:0] sel;
  logic [4:0] cnt;
  logic [4:0] op;

  assign busy = (state != S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:   op = start ? OP_LOAD : OP_NOP;
      S_SQ:     op = OP_SQ;
      S_WT:     op = OP_WT;
      S_MAC:    op = OP_MAC;
      S_DPREP:  op = OP_DPREP;
      S_DIV:    op = OP_DIV;
      S_DIVEND: op = OP_DIVEND;
      S_DIFF:   op = OP_DIFF;
      S_SQR:    op = OP_SQR;
      S_SUM:    op = OP_SUM;
      S_SA:     op = OP_SA;
      S_SB:     op = OP_SB;
      S_SC:     op = OP_SC;
      S_PERP:   op = OP_PERP;
      S_TRI0:   op = OP_TRI0;
      S_TRI1:   op = OP_TRI1;
      default:  op = OP_NOP;
    endcase
  end

  assign cmd.op     = op;
  assign cmd.pt_idx = pt_idx;
  assign cmd.sel    = sel;
  assign cmd.last   = (state == S_TRI1) && (pt_idx == status.seg_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pt_idx <= '0;
      sel    <= '0;
      cnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pt_idx <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: state <= S_WT;
        S_WT: begin
          sel   <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          sel <= sel + 2'd1;
          if (sel == 2'd3) begin
            state <= S_DPREP;
          end
        end
        S_DPREP: begin
          cnt   <= 5'd16;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 5'd0) begin
            state <= S_DIVEND;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_DIVEND: begin
          if (pt_idx == 6'd0) begin
            pt_idx <= 6'd1;
            state  <= S_SQ;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SQR;
        S_SQR:  state <= S_SUM;
        S_SUM: begin
          cnt   <= 5'd7;
          state <= S_SA;
        end
        S_SA: state <= S_SB;
        S_SB: state <= S_SC;
        S_SC: begin
          if (cnt == 5'd0) begin
            state <= S_PERP;
          end else begin
            cnt   <= cnt - 5'd1;
            state <= S_SA;
          end
        end
        S_PERP: state <= S_TRI0;
        S_TRI0: state <= S_TRI1;
        S_TRI1: begin
          if (pt_idx == status.seg_n) begin
            state <= S_IDLE;
          end else begin
            pt_idx <= pt_idx + 6'd1;
            state  <= S_SQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bzt_datapath.sv =====
// Datapath: Bernstein accumulation, rounding divider, offset search and triangle output.
module bzt_datapath
  import bzt_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32
)
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [5:0] seg_cfg,
  input  logic [7:0] thick_cfg,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     ctrl_a_x,
  input  coord_t     ctrl_a_y,
  input  coord_t     ctrl_b_x,
  input  coord_t     ctrl_b_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  output logic       result_strobe,
  output coord_t     vert0_x,
  output coord_t     vert0_y,
  output coord_t     vert1_x,
  output coord_t     vert1_y,
  output coord_t     vert2_x,
  output coord_t     vert2_y,
  output logic       last_triangle
);

  localparam logic [5:0] MaxSeg = 6'(MAX_SEGMENTS);

  coord_t px [4];
  coord_t py [4];
  logic [5:0] seg_n;
  logic [7:0] thick;

  logic [10:0] uu, ii;
  logic [15:0] w [4];
  logic [15:0] den;
  logic signed [31:0] acc_x, acc_y;

  logic [32:0] rem_x, rem_y;
  logic [33:0] dsh;
  logic [16:0] q_x, q_y;
  logic        neg_x, neg_y;

  coord_t cur_x, cur_y, prev_x, prev_y;

  logic [15:0] adx, ady;
  logic        dx_neg, dy_pos;
  logic [31:0] sqx, sqy;
  logic [23:0] atx, aty;
  logic [32:0] s;
  logic [47:0] tgt_x, tgt_y;

  logic [7:0]  mask, rx, ry, cand_x, cand_y;
  logic [15:0] qq_x, qq_y;
  logic [32:0] ph_x, ph_y;
  logic [31:0] pl_x, pl_y;
  logic signed [8:0] perp_x, perp_y;

  assign status.seg_n = seg_n;

  // Bernstein weights
  logic [5:0]  u_cur, i_cur;
  logic [11:0] uu_full, ii_full;
  logic [16:0] w0_full, w3_full, uui, uii, w1_full, w2_full;

  assign i_cur   = cmd.pt_idx;
  assign u_cur   = seg_n - cmd.pt_idx;
  assign uu_full = {6'd0, u_cur} * {6'd0, u_cur};
  assign ii_full = {6'd0, i_cur} * {6'd0, i_cur};
  assign w0_full = {6'd0, uu} * {11'd0, u_cur};
  assign w3_full = {6'd0, ii} * {11'd0, i_cur};
  assign uui     = {6'd0, uu} * {11'd0, i_cur};
  assign uii     = {6'd0, ii} * {11'd0, u_cur};
  assign w1_full = uui + {uui[15:0], 1'b0};
  assign w2_full = uii + {uii[15:0], 1'b0};

  logic signed [32:0] prod_x, prod_y;
  assign prod_x = $signed({1'b0, w[cmd.sel]}) * px[cmd.sel];
  assign prod_y = $signed({1'b0, w[cmd.sel]}) * py[cmd.sel];

  // Rounding division set-up: floor((2 num + den) / (2 den))
  logic [16:0]        dd;
  logic signed [32:0] ax, ay;
  logic [32:0]        nx, ny;
  assign dd = {den, 1'b0};
  assign ax = $signed({acc_x, 1'b0}) + $signed({17'd0, den});
  assign ay = $signed({acc_y, 1'b0}) + $signed({17'd0, den});
  assign nx = 33'(-ax) + {16'd0, dd} - 33'd1;
  assign ny = 33'(-ay) + {16'd0, dd} - 33'd1;

  logic ge_x, ge_y;
  assign ge_x = ({1'b0, rem_x} >= dsh);
  assign ge_y = ({1'b0, rem_y} >= dsh);

  logic signed [16:0] dx, dy;
  logic [16:0] ndx, ndy;
  assign dx  = {cur_x[15], cur_x} - {prev_x[15], prev_x};
  assign dy  = {cur_y[15], cur_y} - {prev_y[15], prev_y};
  assign ndx = 17'(-dx);
  assign ndy = 17'(-dy);

  logic [7:0] c_x, c_y, o_x, o_y;
  logic [8:0] o9_x, o9_y;
  assign c_x  = rx | mask;
  assign c_y  = ry | mask;
  assign o9_x = {c_x, 1'b0} - 9'd1;
  assign o9_y = {c_y, 1'b0} - 9'd1;
  assign o_x  = o9_x[7:0];
  assign o_y  = o9_y[7:0];

  logic [48:0] tot_x, tot_y;
  assign tot_x = {ph_x, 16'd0} + {17'd0, pl_x};
  assign tot_y = {ph_y, 16'd0} + {17'd0, pl_y};

  logic signed [16:0] l1x, l1y, r1x, r1y, l2x, l2y, r2x, r2y;
  assign l1x = {prev_x[15], prev_x} + 17'(perp_x);
  assign l1y = {prev_y[15], prev_y} + 17'(perp_y);
  assign r1x = {prev_x[15], prev_x} - 17'(perp_x);
  assign r1y = {prev_y[15], prev_y} - 17'(perp_y);
  assign l2x = {cur_x[15], cur_x} + 17'(perp_x);
  assign l2y = {cur_y[15], cur_y} + 17'(perp_y);
  assign r2x = {cur_x[15], cur_x} - 17'(perp_x);
  assign r2y = {cur_y[15], cur_y} - 17'(perp_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      seg_n         <= 6'd1;
    end else begin
      result_strobe <= (cmd.op == OP_TRI0) || (cmd.op == OP_TRI1);
      if (cmd.op == OP_LOAD) begin
        if (seg_cfg == 6'd0) begin
          seg_n <= 6'd1;
        end else if (seg_cfg > MaxSeg) begin
          seg_n <= MaxSeg;
        end else begin
          seg_n <= seg_cfg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        px[0] <= start_x;  py[0] <= start_y;
        px[1] <= ctrl_a_x; py[1] <= ctrl_a_y;
        px[2] <= ctrl_b_x; py[2] <= ctrl_b_y;
        px[3] <= end_x;    py[3] <= end_y;
        thick <= thick_cfg;
      end
      OP_SQ: begin
        uu <= uu_full[10:0];
        ii <= ii_full[10:0];
      end
      OP_WT: begin
        w[0]  <= w0_full[15:0];
        w[1]  <= w1_full[15:0];
        w[2]  <= w2_full[15:0];
        w[3]  <= w3_full[15:0];
        acc_x <= '0;
        acc_y <= '0;
        if (cmd.pt_idx == 6'd0) begin
          den <= w0_full[15:0];
        end
      end
      OP_MAC: begin
        acc_x <= acc_x + prod_x[31:0];
        acc_y <= acc_y + prod_y[31:0];
      end
      OP_DPREP: begin
        neg_x <= ax[32];
        neg_y <= ay[32];
        rem_x <= ax[32] ? nx : ax;
        rem_y <= ay[32] ? ny : ay;
        dsh   <= {1'b0, dd, 16'd0};
        q_x   <= '0;
        q_y   <= '0;
      end
      OP_DIV: begin
        if (ge_x) begin
          rem_x <= rem_x - dsh[32:0];
        end
        if (ge_y) begin
          rem_y <= rem_y - dsh[32:0];
        end
        q_x <= {q_x[15:0], ge_x};
        q_y <= {q_y[15:0], ge_y};
        dsh <= {1'b0, dsh[33:1]};
      end
      OP_DIVEND: begin
        cur_x <= neg_x ? 16'(~q_x + 17'd1) : q_x[15:0];
        cur_y <= neg_y ? 16'(~q_y + 17'd1) : q_y[15:0];
        if (cmd.pt_idx == 6'd0) begin
          prev_x <= neg_x ? 16'(~q_x + 17'd1) : q_x[15:0];
          prev_y <= neg_y ? 16'(~q_y + 17'd1) : q_y[15:0];
        end
      end
      OP_DIFF: begin
        adx    <= dx[16] ? ndx[15:0] : dx[15:0];
        ady    <= dy[16] ? ndy[15:0] : dy[15:0];
        dx_neg <= dx[16];
        dy_pos <= !dy[16] && (dy != 17'sd0);
      end
      OP_SQR: begin
        sqx <= {16'd0, adx} * {16'd0, adx};
        sqy <= {16'd0, ady} * {16'd0, ady};
        atx <= {8'd0, adx} * {16'd0, thick};
        aty <= {8'd0, ady} * {16'd0, thick};
      end
      OP_SUM: begin
        s     <= {1'b0, sqx} + {1'b0, sqy};
        tgt_x <= {24'd0, atx} * {24'd0, atx};
        tgt_y <= {24'd0, aty} * {24'd0, aty};
        mask  <= 8'h80;
        rx    <= '0;
        ry    <= '0;
      end
      OP_SA: begin
        cand_x <= c_x;
        cand_y <= c_y;
        qq_x   <= {8'd0, o_x} * {8'd0, o_x};
        qq_y   <= {8'd0, o_y} * {8'd0, o_y};
      end
      OP_SB: begin
        ph_x <= {17'd0, qq_x} * {16'd0, s[32:16]};
        ph_y <= {17'd0, qq_y} * {16'd0, s[32:16]};
        pl_x <= {16'd0, qq_x} * {16'd0, s[15:0]};
        pl_y <= {16'd0, qq_y} * {16'd0, s[15:0]};
      end
      OP_SC: begin
        if (cand_x <= 8'd128 && tot_x <= {1'b0, tgt_x}) begin
          rx <= cand_x;
        end
        if (cand_y <= 8'd128 && tot_y <= {1'b0, tgt_y}) begin
          ry <= cand_y;
        end
        mask <= {1'b0, mask[7:1]};
      end
      OP_PERP: begin
        if (s == 33'd0) begin
          perp_x <= '0;
          perp_y <= '0;
        end else begin
          perp_x <= dy_pos ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
          perp_y <= dx_neg ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        end
      end
      OP_TRI0: begin
        vert0_x       <= sat16(l1x);
        vert0_y       <= sat16(l1y);
        vert1_x       <= sat16(r1x);
        vert1_y       <= sat16(r1y);
        vert2_x       <= sat16(l2x);
        vert2_y       <= sat16(l2y);
        last_triangle <= 1'b0;
      end
      OP_TRI1: begin
        vert0_x       <= sat16(r1x);
        vert0_y       <= sat16(r1y);
        vert1_x       <= sat16(r2x);
        vert1_y       <= sat16(r2y);
        vert2_x       <= sat16(l2x);
        vert2_y       <= sat16(l2y);
        last_triangle <= cmd.last;
        prev_x        <= cur_x;
        prev_y        <= cur_y;
      end
      default: begin
      end
    endcase
  end

endmodule
